// File: hw/rtl/kptp_pkg.sv
// Shared constants and tables for the keyed pixel to polar converter.
package kptp_pkg;

	// Fixed field widths
	localparam int COLOR_BITS   = 32;
	localparam int SPACING_BITS = 16;
	localparam int RADIUS_BITS  = 29;
	localparam int ANGLE_BITS   = 16;

	// Register port
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 4;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
	localparam logic [1:0] REG_KEY_COLOR = 2'd2;
	localparam logic [1:0] REG_SPACING   = 2'd3;

	localparam logic [SPACING_BITS-1:0] SPACING_RESET = 16'd256;

	// Radius saturates here
	localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = 29'd379650048;

	// Half a turn in 16-bit turn units
	localparam logic [ANGLE_BITS-1:0] HALF_TURN = 16'd32768;

	// Extra fractional bits carried by the rotation datapath
	localparam int FRAC_EXTRA = 16;

	// Arctangent of 2^-i in 16-bit turns, rounded to nearest
	localparam int ATAN_ENTRIES = 24;
	localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
		16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0,
		16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0
	};

endpackage

// File: hw/rtl/keyed_pixel_to_polar.sv
// Keyed pixel to polar converter: key filter, rounded square root and CORDIC angle pipeline.

// Takes one pixel word per clock while in_stall is low and, unless its colour equals
// key_color, returns one word with its distance from (origin_x, origin_y) times spacing
// (16 fractional bits, saturating) and its angle from the negative x direction in 16-bit
// turns; a pixel on the origin gives zeros with at_origin set. Sustained rate is one word
// per clock while out_stall is low. The square root resolves one result bit per pipeline
// stage while the CORDIC rotations run alongside it. Each stage holds its word when the one
// after it is full and cannot move on, so bubbles close up and a stalled output still leaves
// room upstream. Registers lie at byte addresses 0, 4, 8 and 12; the user must see that they
// are written only while the pipeline is empty, which the block itself does not enforce.
module keyed_pixel_to_polar
	import kptp_pkg::*;
#(
	parameter int COORD_BITS    = 12,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	// pixel channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [COORD_BITS-1:0]    pixel_x,
	input  logic [COORD_BITS-1:0]    pixel_y,
	input  logic [COLOR_BITS-1:0]    pixel_color,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [RADIUS_BITS-1:0]   scaled_radius,
	output logic [ANGLE_BITS-1:0]    angle_turns,
	output logic                     at_origin
);

	localparam int CW   = COORD_BITS + 1;              // signed offset
	localparam int SQW  = 2 * COORD_BITS;              // one square
	localparam int SUMW = SQW + 1;                     // sum of squares
	localparam int RB   = COORD_BITS + 9;              // root bits
	localparam int NW   = 2 * RB;                      // radicand bits
	localparam int RW   = RB + 2;                      // partial remainder
	localparam int UW   = COORD_BITS + FRAC_EXTRA + 3; // rotation datapath
	localparam int LC   = (RB > CORDIC_STAGES) ? RB : CORDIC_STAGES;
	localparam int PW   = RB + 1 + SPACING_BITS;       // scaled product
	localparam int PADW = UW - CW - FRAC_EXTRA;

	// ---------------- configuration registers ----------------
	logic [COORD_BITS-1:0]   origin_x_q;
	logic [COORD_BITS-1:0]   origin_y_q;
	logic [COLOR_BITS-1:0]   key_color_q;
	logic [SPACING_BITS-1:0] spacing_q;
	logic [1:0]              reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			key_color_q <= '0;
			spacing_q   <= SPACING_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_ORIGIN_X:  origin_x_q  <= pwdata[COORD_BITS-1:0];
				REG_ORIGIN_Y:  origin_y_q  <= pwdata[COORD_BITS-1:0];
				REG_KEY_COLOR: key_color_q <= pwdata[COLOR_BITS-1:0];
				REG_SPACING:   spacing_q   <= pwdata[SPACING_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X:  prdata = APB_DATA_BITS'(origin_x_q);
			REG_ORIGIN_Y:  prdata = APB_DATA_BITS'(origin_y_q);
			REG_KEY_COLOR: prdata = APB_DATA_BITS'(key_color_q);
			REG_SPACING:   prdata = APB_DATA_BITS'(spacing_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- stage enables ----------------
	// A stage loads when it is empty or the stage after it loads.
	logic en_s1, en_s2, en_s3, en_sr, en_sm, en_out;
	logic vld_s1, vld_s2, vld_s3, vld_sr, vld_sm, out_vld_q;
	logic en_sk  [LC];
	logic vld_sk [LC];

	assign en_out   = !out_vld_q || !out_stall;
	assign en_sm    = !vld_sm || en_out;
	assign en_sr    = !vld_sr || en_sm;
	assign en_s3    = !vld_s3 || en_sk[0];
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	// ---------------- stage 1: key filter and offsets ----------------
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic                 at_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid && (pixel_color != key_color_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= $signed({1'b0, pixel_x}) - $signed({1'b0, origin_x_q});
			dy_s1 <= $signed({1'b0, pixel_y}) - $signed({1'b0, origin_y_q});
			at_s1 <= (pixel_x == origin_x_q) && (pixel_y == origin_y_q);
		end
	end

	// ---------------- stage 2: squares, rotation start ----------------
	logic signed [2*CW-1:0] sqx_full, sqy_full;
	logic signed [CW-1:0]   u_init, v_init;
	logic [ANGLE_BITS-1:0]  z_init;
	logic [SQW-1:0]         sqx_s2, sqy_s2;
	logic signed [UW-1:0]   u_s2, v_s2;
	logic [ANGLE_BITS-1:0]  z_s2;
	logic                   at_s2;

	assign sqx_full = dx_s1 * dx_s1;
	assign sqy_full = dy_s1 * dy_s1;

	// vector is (-dx, -dy); fold into the right half plane
	always_comb begin
		if (dx_s1 > 0) begin
			u_init = dx_s1;
			v_init = dy_s1;
			z_init = HALF_TURN;
		end else begin
			u_init = -dx_s1;
			v_init = -dy_s1;
			z_init = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sqx_s2 <= sqx_full[SQW-1:0];
			sqy_s2 <= sqy_full[SQW-1:0];
			u_s2   <= {{PADW{u_init[CW-1]}}, u_init, {FRAC_EXTRA{1'b0}}};
			v_s2   <= {{PADW{v_init[CW-1]}}, v_init, {FRAC_EXTRA{1'b0}}};
			z_s2   <= z_init;
			at_s2  <= at_s1;
		end
	end

	// ---------------- stage 3: radicand ----------------
	logic [SUMW-1:0]       sum_sq;
	logic [NW-1:0]         n_s3;
	logic signed [UW-1:0]  u_s3, v_s3;
	logic [ANGLE_BITS-1:0] z_s3;
	logic                  at_s3;

	assign sum_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			n_s3  <= {1'b0, sum_sq, 16'h0000};
			u_s3  <= u_s2;
			v_s3  <= v_s2;
			z_s3  <= z_s2;
			at_s3 <= at_s2;
		end
	end

	// ---------------- core: root bit and rotation per stage ----------------
	logic [NW-1:0]         n_sk  [LC];
	logic [RW-1:0]         r_sk  [LC];
	logic [RB-1:0]         q_sk  [LC];
	logic signed [UW-1:0]  u_sk  [LC];
	logic signed [UW-1:0]  v_sk  [LC];
	logic [ANGLE_BITS-1:0] z_sk  [LC];
	logic                  at_sk [LC];

	for (genvar j = 0; j < LC; j++) begin : g_core
		logic [NW-1:0]         n_in, n_nx;
		logic [RW-1:0]         r_in, r_nx;
		logic [RB-1:0]         q_in, q_nx;
		logic signed [UW-1:0]  u_in, u_nx, v_in, v_nx;
		logic [ANGLE_BITS-1:0] z_in, z_nx;
		logic                  at_in, vld_in;

		// source of this stage
		if (j == 0) begin : g_first
			assign n_in   = n_s3;
			assign r_in   = '0;
			assign q_in   = '0;
			assign u_in   = u_s3;
			assign v_in   = v_s3;
			assign z_in   = z_s3;
			assign at_in  = at_s3;
			assign vld_in = vld_s3;
		end else begin : g_chain
			assign n_in   = n_sk[j-1];
			assign r_in   = r_sk[j-1];
			assign q_in   = q_sk[j-1];
			assign u_in   = u_sk[j-1];
			assign v_in   = v_sk[j-1];
			assign z_in   = z_sk[j-1];
			assign at_in  = at_sk[j-1];
			assign vld_in = vld_sk[j-1];
		end

		if (j == LC - 1) begin : g_en_last
			assign en_sk[j] = !vld_sk[j] || en_sr;
		end else begin : g_en_mid
			assign en_sk[j] = !vld_sk[j] || en_sk[j+1];
		end

		// restoring square root, two radicand bits in, one root bit out
		if (j < RB) begin : g_sqrt
			logic [RW-1:0] r_sh, trial;
			logic          ge;
			assign r_sh  = {r_in[RW-3:0], n_in[NW-1 -: 2]};
			assign trial = {q_in, 2'b01};
			assign ge    = r_sh >= trial;
			assign n_nx  = n_in << 2;
			assign r_nx  = ge ? (r_sh - trial) : r_sh;
			assign q_nx  = {q_in[RB-2:0], ge};
		end else begin : g_sqrt_done
			assign n_nx = n_in;
			assign r_nx = r_in;
			assign q_nx = q_in;
		end

		// vectoring rotation; stops moving once v is exactly zero
		if (j < CORDIC_STAGES) begin : g_rot
			logic signed [UW-1:0] su, sv;
			assign su = u_in >>> j;
			assign sv = v_in >>> j;
			always_comb begin
				if (v_in > 0) begin
					u_nx = u_in + sv;
					v_nx = v_in - su;
					z_nx = z_in + ATAN_TURNS[j];
				end else if (v_in < 0) begin
					u_nx = u_in - sv;
					v_nx = v_in + su;
					z_nx = z_in - ATAN_TURNS[j];
				end else begin
					u_nx = u_in;
					v_nx = v_in;
					z_nx = z_in;
				end
			end
		end else begin : g_rot_done
			assign u_nx = u_in;
			assign v_nx = v_in;
			assign z_nx = z_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[j] <= 1'b0;
			end else if (en_sk[j]) begin
				vld_sk[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sk[j]) begin
				n_sk[j]  <= n_nx;
				r_sk[j]  <= r_nx;
				q_sk[j]  <= q_nx;
				u_sk[j]  <= u_nx;
				v_sk[j]  <= v_nx;
				z_sk[j]  <= z_nx;
				at_sk[j] <= at_in;
			end
		end
	end

	// ---------------- round to nearest ----------------
	logic                  rnd_up;
	logic [RB:0]           rq_sr;
	logic [ANGLE_BITS-1:0] z_sr;
	logic                  at_sr;

	// remainder above the root means the true root lies past the half point
	assign rnd_up = r_sk[LC-1] > {2'b00, q_sk[LC-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else if (en_sr) begin
			vld_sr <= vld_sk[LC-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sr) begin
			rq_sr <= {1'b0, q_sk[LC-1]} + {{RB{1'b0}}, rnd_up};
			z_sr  <= z_sk[LC-1];
			at_sr <= at_sk[LC-1];
		end
	end

	// ---------------- spacing multiply ----------------
	logic [PW-1:0]         prod_c, prod_sm;
	logic [ANGLE_BITS-1:0] z_sm;
	logic                  at_sm;

	assign prod_c = rq_sr * spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (en_sm) begin
			vld_sm <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (en_sm) begin
			prod_sm <= prod_c;
			z_sm    <= z_sr;
			at_sm   <= at_sr;
		end
	end

	// ---------------- output register: saturate, origin override ----------------
	logic [RADIUS_BITS-1:0] radius_q;
	logic [ANGLE_BITS-1:0]  angle_q;
	logic                   at_origin_q;
	logic                   sat;

	assign sat = prod_sm > {{(PW-RADIUS_BITS){1'b0}}, RADIUS_MAX};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en_out) begin
			out_vld_q <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			if (at_sm) begin
				radius_q <= '0;
				angle_q  <= '0;
			end else begin
				radius_q <= sat ? RADIUS_MAX : prod_sm[RADIUS_BITS-1:0];
				angle_q  <= z_sm;
			end
			at_origin_q <= at_sm;
		end
	end

	assign out_valid     = out_vld_q;
	assign scaled_radius = radius_q;
	assign angle_turns   = angle_q;
	assign at_origin     = at_origin_q;

	// ---------------- assertions ----------------
`ifndef ASSERT_OFF
	// a key-coloured word never enters the pipeline
	a_key_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (pixel_color == key_color_q)) |=> !vld_s1)
		else $error("key-coloured word entered the pipeline");

	// the input is held off only while the first stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stalled with an empty first stage");

	// origin words carry zero radius and zero angle
	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && at_origin) |-> ((scaled_radius == '0) && (angle_turns == '0)))
		else $error("origin word with non-zero radius or angle");

	// radius never passes the saturation limit
	a_radius_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scaled_radius <= RADIUS_MAX))
		else $error("radius above saturation limit");
`endif

endmodule
